[src/tlss_pkg.sv]
// Shared constants, codes and types of the two-level slot swap table.
`timescale 1ns / 1ps

package tlss_pkg;

  // Table geometry.
  localparam int SLOTS    = 8;
  localparam int ID_BITS  = 16;
  localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_BITS = $clog2(SLOTS + 1);

  // Fixed field widths of the request and result channels.
  localparam int MODE_W    = 3;
  localparam int PID_W     = 16;
  localparam int STATUS_W  = 3;
  localparam int SLOT_W    = 3;
  localparam int COUNT_W   = 4;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Operation codes carried in the mode field.
  typedef enum logic [MODE_W-1:0] {
    MODE_CLR_PRI   = 3'd0,
    MODE_CLR_SEC   = 3'd1,
    MODE_ALLOC     = 3'd2,
    MODE_SWAP_OUT  = 3'd3,
    MODE_SWAP_IN   = 3'd4,
    MODE_TERMINATE = 3'd5,
    MODE_REMOVE    = 3'd6
  } mode_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_ZERO_ID   = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_PRI_FULL  = 3'd3,
    ST_SEC_FULL  = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN_SRC,
    FSM_SCAN_DST,
    FSM_FINISH
  } fsm_t;

  // Write and invalidate controls for one slot table.
  typedef struct packed {
    logic                wr_en;
    logic [IDX_BITS-1:0] wr_addr;
    logic [ID_BITS-1:0]  wr_data;
    logic                inv_en;
    logic [IDX_BITS-1:0] inv_addr;
    logic                inv_all;
  } tbl_ctrl_t;

endpackage

[src/tlss_if.sv]
// Request and result channel interfaces of the slot swap table.
`timescale 1ns / 1ps

interface tlss_req_if import tlss_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [PID_W-1:0]  process_id;

  modport source (output valid, mode, process_id, input ready);
  modport sink   (input valid, mode, process_id, output ready);
endinterface

interface tlss_rsp_if import tlss_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [COUNT_W-1:0]  cleared_count;

  modport source (output valid, status, slot, cleared_count, input ready);
  modport sink   (input valid, status, slot, cleared_count, output ready);
endinterface

[src/two_level_slot_swap_table_unit.sv]
// Top level: sequencer that scans and updates the primary and secondary slot tables.
// Clears, unused modes and zero identifiers go straight to the result; allocate, terminate
// and remove scan one table; swaps scan the source table, then the destination if found.
// One request at a time, accepted the cycle after the previous result is registered; each
// scan reads a table through its single registered read port, and the result waits until
// the result register is free. Synchronous reset empties both tables through their valid bits.
`timescale 1ns / 1ps

module two_level_slot_swap_table_unit import tlss_pkg::*; (
  input logic       clk,
  input logic       rst,
  tlss_req_if.sink  req,
  tlss_rsp_if.source rsp
);

  fsm_t                state, state_next;
  mode_t               op;
  logic [ID_BITS-1:0]  id;
  logic [CNT_BITS-1:0] cnt;
  logic                proc_en;
  logic [IDX_BITS-1:0] proc_idx;
  logic                found, efound;
  logic [IDX_BITS-1:0] src_idx, e_idx;
  logic [COUNT_W-1:0]  clr_cnt;

  logic                out_valid;
  status_t             out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [COUNT_W-1:0]  out_count;

  tbl_ctrl_t           pri_ctrl, sec_ctrl;
  logic [ID_BITS-1:0]  pri_rd, sec_rd, scan_data;
  logic [IDX_BITS-1:0] rd_addr;
  logic                scan_sec, scanning, scan_last, hit, hole, is_purge;
  logic                needs_scan, out_free, load;
  status_t             res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [COUNT_W-1:0]  res_count;
  mode_t               req_mode;

  // Slot table memories.
  tlss_table u_pri (.clk(clk), .rst(rst), .rd_addr(rd_addr), .ctrl(pri_ctrl), .rd_data(pri_rd));
  tlss_table u_sec (.clk(clk), .rst(rst), .rd_addr(rd_addr), .ctrl(sec_ctrl), .rd_data(sec_rd));

  // Scan datapath: read data belongs to the slot addressed in the previous cycle.
  assign req_mode  = mode_t'(req.mode);
  assign rd_addr   = cnt[IDX_BITS-1:0];
  assign scanning  = (state == FSM_SCAN_SRC) || (state == FSM_SCAN_DST);
  assign scan_last = (cnt == CNT_BITS'(SLOTS));
  assign scan_sec  = (state == FSM_SCAN_DST) ? (op == MODE_SWAP_OUT)
                                             : (op == MODE_SWAP_IN || op == MODE_REMOVE);
  assign scan_data = scan_sec ? sec_rd : pri_rd;
  assign hit       = proc_en && (state == FSM_SCAN_SRC) && (scan_data == id);
  assign hole      = proc_en && (scan_data == '0);
  assign is_purge  = (op == MODE_TERMINATE) || (op == MODE_REMOVE);
  assign out_free  = !out_valid || rsp.ready;

  // A request needs a scan only for table operations with a nonzero identifier.
  always_comb begin
    needs_scan = 1'b0;
    unique case (req_mode)
      MODE_ALLOC, MODE_SWAP_OUT, MODE_SWAP_IN, MODE_TERMINATE, MODE_REMOVE:
        needs_scan = (ID_BITS'(req.process_id) != '0);
      default: needs_scan = 1'b0;
    endcase
  end

  // Sequencer next state, table updates and result formation.
  always_comb begin
    state_next = state;
    pri_ctrl   = '0;
    sec_ctrl   = '0;
    req.ready  = 1'b0;
    load       = 1'b0;
    res_status = ST_OK;
    res_slot   = '0;
    res_count  = '0;
    unique case (state)
      FSM_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = needs_scan ? FSM_SCAN_SRC : FSM_FINISH;
        end
      end
      FSM_SCAN_SRC: begin
        if (hit && is_purge) begin
          if (scan_sec) begin
            sec_ctrl.inv_en   = 1'b1;
            sec_ctrl.inv_addr = proc_idx;
          end else begin
            pri_ctrl.inv_en   = 1'b1;
            pri_ctrl.inv_addr = proc_idx;
          end
        end
        if (scan_last) begin
          state_next = ((op == MODE_SWAP_OUT || op == MODE_SWAP_IN) && (found || hit))
                       ? FSM_SCAN_DST : FSM_FINISH;
        end
      end
      FSM_SCAN_DST: begin
        if (scan_last) begin
          state_next = FSM_FINISH;
        end
      end
      FSM_FINISH: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = FSM_IDLE;
          unique case (op)
            MODE_CLR_PRI: pri_ctrl.inv_all = 1'b1;
            MODE_CLR_SEC: sec_ctrl.inv_all = 1'b1;
            MODE_ALLOC: begin
              if (id == '0) begin
                res_status = ST_ZERO_ID;
              end else if (found) begin
                res_status = ST_DUPLICATE;
              end else if (!efound) begin
                res_status = ST_PRI_FULL;
              end else begin
                pri_ctrl.wr_en   = 1'b1;
                pri_ctrl.wr_addr = e_idx;
                pri_ctrl.wr_data = id;
                res_slot         = SLOT_W'(e_idx);
              end
            end
            MODE_SWAP_OUT: begin
              if (id == '0) begin
                res_status = ST_ZERO_ID;
              end else if (!found) begin
                res_status = ST_NOT_FOUND;
              end else if (!efound) begin
                res_status = ST_SEC_FULL;
              end else begin
                sec_ctrl.wr_en    = 1'b1;
                sec_ctrl.wr_addr  = e_idx;
                sec_ctrl.wr_data  = id;
                pri_ctrl.inv_en   = 1'b1;
                pri_ctrl.inv_addr = src_idx;
                res_slot          = SLOT_W'(e_idx);
              end
            end
            MODE_SWAP_IN: begin
              if (id == '0) begin
                res_status = ST_ZERO_ID;
              end else if (!found) begin
                res_status = ST_NOT_FOUND;
              end else if (!efound) begin
                res_status = ST_PRI_FULL;
              end else begin
                pri_ctrl.wr_en    = 1'b1;
                pri_ctrl.wr_addr  = e_idx;
                pri_ctrl.wr_data  = id;
                sec_ctrl.inv_en   = 1'b1;
                sec_ctrl.inv_addr = src_idx;
                res_slot          = SLOT_W'(e_idx);
              end
            end
            MODE_TERMINATE, MODE_REMOVE: res_count = clr_cnt;
            default: res_status = ST_OK;
          endcase
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FSM_IDLE;
      proc_en   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      proc_en <= scanning && !scan_last;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture and scan bookkeeping.
  always_ff @(posedge clk) begin
    proc_idx <= cnt[IDX_BITS-1:0];
    if (state == FSM_IDLE && req.valid) begin
      op      <= req_mode;
      id      <= ID_BITS'(req.process_id);
      cnt     <= '0;
      found   <= 1'b0;
      efound  <= 1'b0;
      clr_cnt <= '0;
    end else if (scanning) begin
      cnt <= scan_last ? '0 : cnt + CNT_BITS'(1);
      if (hit) begin
        if (!found) begin
          found   <= 1'b1;
          src_idx <= proc_idx;
        end
        if (is_purge && clr_cnt != COUNT_MAX) begin
          clr_cnt <= clr_cnt + COUNT_W'(1);
        end
      end
      // The destination scan looks for its own first empty slot.
      if (state_next == FSM_SCAN_DST && state == FSM_SCAN_SRC) begin
        efound <= 1'b0;
      end else if (hole && !efound) begin
        efound <= 1'b1;
        e_idx  <= proc_idx;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_count  <= res_count;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.slot          = out_slot;
  assign rsp.cleared_count = out_count;

  // An accepted request always leaves the idle state.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != FSM_IDLE))
    else $error("accepted request did not start the sequencer");

  // The scan counter never runs past SLOTS, one beyond the last slot index.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    scanning |-> (cnt <= CNT_BITS'(SLOTS)))
    else $error("scan counter out of range");

  // A finished request presents its result on the next cycle.
  a_load_presents: assert property (@(posedge clk) disable iff (rst)
    load |=> (rsp.valid && state == FSM_IDLE))
    else $error("result not presented after finish");

  // The table is only written back when the result register can take the result.
  a_write_with_load: assert property (@(posedge clk) disable iff (rst)
    (pri_ctrl.wr_en || sec_ctrl.wr_en) |-> (load && out_free))
    else $error("table write without result load");

endmodule

[src/tlss_table.sv]
// One slot table: synchronous memory with per-slot valid bits.
`timescale 1ns / 1ps

module tlss_table import tlss_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [IDX_BITS-1:0] rd_addr,
  input  tbl_ctrl_t           ctrl,
  output logic [ID_BITS-1:0]  rd_data
);

  logic [ID_BITS-1:0] mem [SLOTS];
  logic [SLOTS-1:0]   vld;
  logic [ID_BITS-1:0] rd_q;
  logic               rd_vld;

  // Memory write port and registered read port.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= ctrl.wr_data;
    end
    rd_q   <= mem[rd_addr];
    rd_vld <= vld[rd_addr];
  end

  // Valid bits: an invalid slot reads as empty, so reset and clears are immediate.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctrl.inv_all) begin
      vld <= '0;
    end else begin
      if (ctrl.inv_en) begin
        vld[ctrl.inv_addr] <= 1'b0;
      end
      if (ctrl.wr_en) begin
        vld[ctrl.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule
